// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the turn maneuver sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tms_pkg.sv -----
// Package with the types, codes and constants of the turn maneuver sequencer.
`default_nettype none

package tms_pkg;

    localparam int SENSOR_W = 7;
    localparam int TIME_W   = 32;
    localparam int SPEED_W  = 10;
    localparam int DUR_W    = 16;
    localparam int TARGET_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CROSS = 2'd1,
        KIND_LEFT  = 2'd2,
        KIND_RIGHT = 2'd3
    } turn_kind_t;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_TIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_END      = 3'd4;

    localparam logic [SPEED_W-1:0] BASE_SPEED_RST    = 10'd20;
    localparam logic [SPEED_W-1:0] ROTATE_SPEED_RST  = 10'd30;
    localparam logic [DUR_W-1:0]   CROSS_TIME_RST    = 16'd300;
    localparam logic [DUR_W-1:0]   STRAIGHT_TIME_RST = 16'd200;
    localparam logic [DUR_W-1:0]   TURN_END_RST      = 16'd700;

    localparam logic [SENSOR_W-1:0] PAT_CROSS  = 7'h7F;
    localparam logic [SENSOR_W-1:0] LEFT_CORE  = 7'h07;
    localparam logic [SENSOR_W-1:0] LEFT_SIDE  = 7'h78;
    localparam logic [SENSOR_W-1:0] RIGHT_CORE = 7'h70;
    localparam logic [SENSOR_W-1:0] RIGHT_SIDE = 7'h0F;
    localparam logic [SENSOR_W-1:0] CLEAR_MASK = 7'h77;

    typedef struct packed {
        logic [SPEED_W-1:0] base_speed;
        logic [SPEED_W-1:0] rotate_speed;
        logic [DUR_W-1:0]   cross_time;
        logic [DUR_W-1:0]   straight_time;
        logic [DUR_W-1:0]   turn_end;
    } tms_cfg_t;

    typedef struct packed {
        turn_kind_t kind;
        logic       cleared;
    } tms_class_t;

endpackage

`default_nettype wire

// ----- rtl/tms_cfg_regs.sv -----
// Configuration register file of the turn maneuver sequencer.
`default_nettype none

module tms_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tms_pkg::CFG_DATA_W-1:0] cfg_data,
    output tms_pkg::tms_cfg_t                   cfg
);
    import tms_pkg::*;

    tms_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed    <= BASE_SPEED_RST;
            cfg_reg.rotate_speed  <= ROTATE_SPEED_RST;
            cfg_reg.cross_time    <= CROSS_TIME_RST;
            cfg_reg.straight_time <= STRAIGHT_TIME_RST;
            cfg_reg.turn_end      <= TURN_END_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_SPEED:    cfg_reg.base_speed    <= cfg_data[SPEED_W-1:0];
                REG_ROTATE_SPEED:  cfg_reg.rotate_speed  <= cfg_data[SPEED_W-1:0];
                REG_CROSS_TIME:    cfg_reg.cross_time    <= cfg_data[DUR_W-1:0];
                REG_STRAIGHT_TIME: cfg_reg.straight_time <= cfg_data[DUR_W-1:0];
                REG_TURN_END:      cfg_reg.turn_end      <= cfg_data[DUR_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tms_classify.sv -----
// Sensor pattern classifier: turn kind and re-arm condition.
`default_nettype none

module tms_classify (
    input  wire logic [tms_pkg::SENSOR_W-1:0] sensor_bits,
    output tms_pkg::tms_class_t               result
);
    import tms_pkg::*;

    turn_kind_t kind;

    always_comb
    begin
        if (sensor_bits == PAT_CROSS)
            kind = KIND_CROSS;
        else if (((sensor_bits & LEFT_CORE) == LEFT_CORE) && ((sensor_bits & LEFT_SIDE) != '0))
            kind = KIND_LEFT;
        else if (((sensor_bits & RIGHT_CORE) == RIGHT_CORE)
                 && ((sensor_bits & RIGHT_SIDE) != '0))
            kind = KIND_RIGHT;
        else
            kind = KIND_NONE;
    end

    assign result.kind    = kind;
    assign result.cleared = ((sensor_bits & CLEAR_MASK) == '0) || (kind == KIND_NONE);

endmodule

`default_nettype wire

// ----- rtl/turn_maneuver_sequencer.sv -----
// Top level of the turn maneuver sequencer: request register, turn state and result register.
`default_nettype none

// One request is taken per clock cycle unless the input side stalls: the request
// is registered, the pattern is classified and the turn state and wheel targets
// are worked out in one pass, and the outcome lands in the result register. A
// stall on the result side holds both registers, and the input side stalls only
// when the request register is full and cannot move on. Configuration writes are
// taken in every cycle.

`include "assert_macros.svh"

module turn_maneuver_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [tms_pkg::SENSOR_W-1:0]   sensor_bits,
    input  wire logic [tms_pkg::TIME_W-1:0]     now_ms,
    input  wire logic                           restart,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                takeover,
    output logic signed [tms_pkg::TARGET_W-1:0] left_target,
    output logic signed [tms_pkg::TARGET_W-1:0] right_target,
    output logic [1:0]                          turn_kind,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tms_pkg::*;

    tms_cfg_t   cfg;
    tms_class_t cls;

    logic                s1_valid_reg;
    logic [SENSOR_W-1:0] s1_bits_reg;
    logic [TIME_W-1:0]   s1_now_reg;
    logic                s1_restart_reg;
    logic                s1_advance;

    turn_kind_t        turn_reg, turn_next;
    logic              active_reg, active_next;
    logic              armed_reg, armed_next;
    logic [TIME_W-1:0] start_reg, start_next;

    logic                       out_valid_reg;
    logic                       takeover_reg, takeover_next;
    logic signed [TARGET_W-1:0] left_reg, left_next;
    logic signed [TARGET_W-1:0] right_reg, right_next;
    turn_kind_t                 kind_reg;

    logic [TIME_W-1:0]          elapsed;
    logic signed [TARGET_W-1:0] base_t;
    logic signed [TARGET_W-1:0] rot_t;
    logic                       running;

    tms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tms_classify u_classify (
        .sensor_bits (s1_bits_reg),
        .result      (cls)
    );

    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;

    assign base_t = $signed({1'b0, cfg.base_speed});
    assign rot_t  = $signed({1'b0, cfg.rotate_speed});

    always_comb
    begin
        turn_next     = turn_reg;
        active_next   = active_reg;
        armed_next    = armed_reg;
        start_next    = start_reg;
        takeover_next = 1'b0;
        left_next     = '0;
        right_next    = '0;
        running       = active_reg;
        elapsed       = '0;

        if (s1_restart_reg)
        begin
            turn_next   = KIND_NONE;
            active_next = 1'b0;
            armed_next  = 1'b1;
            start_next  = '0;
            running     = 1'b0;
        end
        else
        begin
            if (!active_reg && (armed_reg || cls.cleared))
            begin
                armed_next = 1'b1;
                if (cls.kind != KIND_NONE)
                begin
                    turn_next   = cls.kind;
                    active_next = 1'b1;
                    armed_next  = 1'b0;
                    start_next  = s1_now_reg;
                    running     = 1'b1;
                end
            end

            if (running)
            begin
                elapsed = s1_now_reg - start_next;
                if (turn_next == KIND_CROSS)
                begin
                    if (elapsed >= TIME_W'(cfg.cross_time))
                    begin
                        active_next = 1'b0;
                        turn_next   = KIND_NONE;
                    end
                    else
                    begin
                        takeover_next = 1'b1;
                        left_next     = base_t;
                        right_next    = base_t;
                    end
                end
                else if (elapsed < TIME_W'(cfg.straight_time))
                begin
                    takeover_next = 1'b1;
                    left_next     = base_t;
                    right_next    = base_t;
                end
                else if (elapsed < TIME_W'(cfg.turn_end))
                begin
                    takeover_next = 1'b1;
                    if (turn_next == KIND_LEFT)
                    begin
                        left_next  = -rot_t;
                        right_next = rot_t;
                    end
                    else
                    begin
                        left_next  = rot_t;
                        right_next = -rot_t;
                    end
                end
                else
                begin
                    active_next = 1'b0;
                    turn_next   = KIND_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            turn_reg      <= KIND_NONE;
            active_reg    <= 1'b0;
            armed_reg     <= 1'b1;
            start_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_valid_reg && s1_advance)
            begin
                turn_reg   <= turn_next;
                active_reg <= active_next;
                armed_reg  <= armed_next;
                start_reg  <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_bits_reg    <= sensor_bits;
            s1_now_reg     <= now_ms;
            s1_restart_reg <= restart;
        end
        if (s1_valid_reg && s1_advance)
        begin
            takeover_reg <= takeover_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            kind_reg     <= turn_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign takeover     = takeover_reg;
    assign left_target  = left_reg;
    assign right_target = right_reg;
    assign turn_kind    = kind_reg;

    `ASSERT_SAME(a_idle_targets_zero, clk, rst_n, out_valid_reg && !takeover_reg,
        (left_reg == '0) && (right_reg == '0), "Targets not zero without takeover")
    `ASSERT_SAME(a_takeover_has_kind, clk, rst_n, out_valid_reg && takeover_reg,
        kind_reg != KIND_NONE, "Takeover reported with no turn")
    `ASSERT_SAME(a_active_disarmed, clk, rst_n, active_reg,
        !armed_reg && (turn_reg != KIND_NONE), "Active turn while armed or with no kind")
    `ASSERT_NEXT(a_restart_clears, clk, rst_n, s1_valid_reg && s1_advance && s1_restart_reg,
        !active_reg && armed_reg && (turn_reg == KIND_NONE), "Restart did not clear state")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the turn maneuver sequencer with a per-request behavior predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tms_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int ROUTE_ROWS   = 24;
    localparam int PHASE_ITEMS  = 210;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AFTER   = 500;
    localparam int SETTLE       = 8;

    typedef struct packed {
        logic                       takeover;
        logic signed [TARGET_W-1:0] left_w;
        logic signed [TARGET_W-1:0] right_w;
        turn_kind_t                 kind;
    } wheel_cmd_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor;
        logic [TIME_W-1:0]   stamp;
        logic                clear_req;
        logic                typed;
        wheel_cmd_t          want;
    } route_row_t;

    localparam route_row_t ROUTE [ROUTE_ROWS] = '{
        '{7'h00, 32'd0,        1'b0, 1'b1, '{1'b0, 11'sd0,   11'sd0,   KIND_NONE}},
        '{7'h7F, 32'd1000,     1'b0, 1'b1, '{1'b1, 11'sd20,  11'sd20,  KIND_CROSS}},
        '{7'h7F, 32'd1299,     1'b0, 1'b1, '{1'b1, 11'sd20,  11'sd20,  KIND_CROSS}},
        '{7'h7F, 32'd1300,     1'b0, 1'b1, '{1'b0, 11'sd0,   11'sd0,   KIND_NONE}},
        '{7'h7F, 32'd1301,     1'b0, 1'b0, '0},
        '{7'h08, 32'd1302,     1'b0, 1'b0, '0},
        '{7'h0F, 32'd2000,     1'b0, 1'b1, '{1'b1, 11'sd20,  11'sd20,  KIND_LEFT}},
        '{7'h0F, 32'd2199,     1'b0, 1'b0, '0},
        '{7'h0F, 32'd2200,     1'b0, 1'b1, '{1'b1, -11'sd30, 11'sd30,  KIND_LEFT}},
        '{7'h0F, 32'd2699,     1'b0, 1'b0, '0},
        '{7'h0F, 32'd2700,     1'b0, 1'b1, '{1'b0, 11'sd0,   11'sd0,   KIND_NONE}},
        '{7'h77, 32'd2701,     1'b0, 1'b0, '0},
        '{7'h00, 32'd2702,     1'b0, 1'b0, '0},
        '{7'h71, 32'hFFFFFF00, 1'b0, 1'b1, '{1'b1, 11'sd20,  11'sd20,  KIND_RIGHT}},
        '{7'h71, 32'h00000100, 1'b0, 1'b1, '{1'b1, 11'sd30,  -11'sd30, KIND_RIGHT}},
        '{7'h7F, 32'h00000101, 1'b1, 1'b1, '{1'b0, 11'sd0,   11'sd0,   KIND_NONE}},
        '{7'h7E, 32'd5,        1'b0, 1'b0, '0},
        '{7'h3F, 32'd400,      1'b1, 1'b1, '{1'b0, 11'sd0,   11'sd0,   KIND_NONE}},
        '{7'h07, 32'd10,       1'b0, 1'b0, '0},
        '{7'h70, 32'd20,       1'b0, 1'b0, '0},
        '{7'h7F, 32'hFFFFFFFF, 1'b0, 1'b0, '0},
        '{7'h00, 32'hFFFFFFFF, 1'b1, 1'b1, '{1'b0, 11'sd0,   11'sd0,   KIND_NONE}},
        '{7'h7F, 32'h80000000, 1'b0, 1'b0, '0},
        '{7'h55, 32'h80000100, 1'b0, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [SENSOR_W-1:0]   sensor_bits;
    logic [TIME_W-1:0]     now_ms;
    logic                  restart;
    logic                  out_valid;
    logic                  out_stall;
    logic                  takeover;
    logic signed [TARGET_W-1:0] left_target;
    logic signed [TARGET_W-1:0] right_target;
    logic [1:0]            turn_kind;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [SPEED_W-1:0] lim_base     = BASE_SPEED_RST;
    logic [SPEED_W-1:0] lim_rot      = ROTATE_SPEED_RST;
    logic [DUR_W-1:0]   lim_cross    = CROSS_TIME_RST;
    logic [DUR_W-1:0]   lim_straight = STRAIGHT_TIME_RST;
    logic [DUR_W-1:0]   lim_end      = TURN_END_RST;

    turn_kind_t        trk_kind   = KIND_NONE;
    bit                trk_active = 1'b0;
    bit                trk_armed  = 1'b1;
    logic [TIME_W-1:0] trk_start  = '0;

    wheel_cmd_t        pending_cmds [$];
    wheel_cmd_t        oldest_cmd;
    int                errors      = 0;
    int                sent_count  = 0;
    int                cycle_count = 0;
    bit                tx_calm     = 1'b0;
    bit                rx_calm     = 1'b0;
    bit                pressure_on = 1'b0;
    bit                pressure_done = 1'b0;
    logic [TIME_W-1:0] road_ms     = '0;

    turn_maneuver_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sensor_bits  (sensor_bits),
        .now_ms       (now_ms),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .takeover     (takeover),
        .left_target  (left_target),
        .right_target (right_target),
        .turn_kind    (turn_kind),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic turn_kind_t classify_pattern(input logic [SENSOR_W-1:0] p);
        if (p == PAT_CROSS)
            return KIND_CROSS;
        if ((p & LEFT_CORE) == LEFT_CORE && (p & LEFT_SIDE) != '0)
            return KIND_LEFT;
        if ((p & RIGHT_CORE) == RIGHT_CORE && (p & RIGHT_SIDE) != '0)
            return KIND_RIGHT;
        return KIND_NONE;
    endfunction

    function automatic wheel_cmd_t advance_turn(input logic [SENSOR_W-1:0] p,
                                                input logic [TIME_W-1:0] now,
                                                input logic clear_req);
        wheel_cmd_t                 cmd;
        logic [TIME_W-1:0]          elapsed;
        logic signed [TARGET_W-1:0] cruise;
        logic signed [TARGET_W-1:0] spin;
        turn_kind_t                 seen;
        cmd = '0;
        cruise = {1'b0, lim_base};
        spin = {1'b0, lim_rot};
        if (clear_req) begin
            trk_kind = KIND_NONE;
            trk_active = 1'b0;
            trk_armed = 1'b1;
            trk_start = '0;
            cmd.kind = trk_kind;
            return cmd;
        end
        if (!trk_active) begin
            seen = classify_pattern(p);
            if (!trk_armed) begin
                if (p != '0 && (p & CLEAR_MASK) != '0 && seen != KIND_NONE) begin
                    cmd.kind = trk_kind;
                    return cmd;
                end
                trk_armed = 1'b1;
            end
            if (seen == KIND_NONE) begin
                cmd.kind = trk_kind;
                return cmd;
            end
            trk_kind = seen;
            trk_active = 1'b1;
            trk_armed = 1'b0;
            trk_start = now;
        end
        elapsed = now - trk_start;
        if (trk_kind == KIND_CROSS) begin
            if (elapsed >= TIME_W'(lim_cross))
                trk_active = 1'b0;
            else
                cmd = '{1'b1, cruise, cruise, trk_kind};
        end
        else if (elapsed < TIME_W'(lim_straight)) begin
            cmd = '{1'b1, cruise, cruise, trk_kind};
        end
        else if (elapsed < TIME_W'(lim_end)) begin
            if (trk_kind == KIND_LEFT)
                cmd = '{1'b1, -spin, spin, trk_kind};
            else
                cmd = '{1'b1, spin, -spin, trk_kind};
        end
        else begin
            trk_active = 1'b0;
        end
        if (!trk_active)
            trk_kind = KIND_NONE;
        cmd.kind = trk_kind;
        return cmd;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SENSOR_W-1:0] make_turn_pattern(input turn_kind_t k);
        case (k)
            KIND_CROSS: return PAT_CROSS;
            KIND_LEFT:  return LEFT_CORE | SENSOR_W'($urandom_range(1, 15) << 3);
            default:    return RIGHT_CORE | SENSOR_W'($urandom_range(1, 15));
        endcase
    endfunction

    function automatic logic [SENSOR_W-1:0] make_clear_pattern();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return SENSOR_W'($urandom) & ~CLEAR_MASK;
            default: return SENSOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_offset();
        case ($urandom_range(0, 8))
            0:       return '0;
            1:       return TIME_W'(lim_straight) - 1;
            2:       return TIME_W'(lim_straight);
            3:       return TIME_W'(lim_end) - 1;
            4:       return TIME_W'(lim_end);
            5:       return TIME_W'(lim_cross) - 1;
            6:       return TIME_W'(lim_cross);
            7:       return TIME_W'($urandom_range(0, 70000));
            default: return TIME_W'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [SENSOR_W-1:0] s, input logic [TIME_W-1:0] t,
                                input logic clear_req, input logic typed,
                                input wheel_cmd_t want);
        wheel_cmd_t predicted;
        int         gap;
        @(negedge clk);
        in_valid <= 1'b1;
        sensor_bits <= s;
        now_ms <= t;
        restart <= clear_req;
        do
            @(posedge clk);
        while (in_stall);
        predicted = advance_turn(s, t, clear_req);
        pending_cmds.push_back(typed ? want : predicted);
        sent_count++;
        if ($urandom_range(0, 99) == 0)
            tx_calm = !tx_calm;
        gap = pressure_on ? 0 : pick_gap(tx_calm);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_BASE_SPEED:    lim_base = val[SPEED_W-1:0];
            REG_ROTATE_SPEED:  lim_rot = val[SPEED_W-1:0];
            REG_CROSS_TIME:    lim_cross = val;
            REG_STRAIGHT_TIME: lim_straight = val;
            REG_TURN_END:      lim_end = val;
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_limits(input logic [SPEED_W-1:0] b, input logic [SPEED_W-1:0] r,
                                  input logic [DUR_W-1:0] c, input logic [DUR_W-1:0] s,
                                  input logic [DUR_W-1:0] e);
        write_reg(REG_BASE_SPEED, {6'($urandom), b});
        write_reg(REG_ROTATE_SPEED, {6'($urandom), r});
        write_reg(REG_CROSS_TIME, c);
        write_reg(REG_STRAIGHT_TIME, s);
        write_reg(REG_TURN_END, e);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic drive_episode();
        turn_kind_t        k;
        logic [SENSOR_W-1:0] pat;
        logic [TIME_W-1:0] t0;
        int                n;
        k = turn_kind_t'($urandom_range(1, 3));
        pat = make_turn_pattern(k);
        t0 = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom) : road_ms;
        n = $urandom_range(2, 7);
        send_request(pat, t0, 1'b0, 1'b0, '0);
        repeat (n)
            send_request(($urandom_range(0, 3) == 0) ? SENSOR_W'($urandom) : pat,
                         t0 + pick_offset(), $urandom_range(0, 59) == 0, 1'b0, '0);
        repeat ($urandom_range(1, 2))
            send_request(make_clear_pattern(), t0 + TIME_W'($urandom_range(0, 70000)),
                         1'b0, 1'b0, '0);
        road_ms = t0 + TIME_W'($urandom_range(70001, 140000));
    endtask

    task automatic match_field(input string tag, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: result with no request pending, takeover %0d kind %0d",
                         $time, takeover, turn_kind);
                errors++;
            end
            else begin
                oldest_cmd = pending_cmds.pop_front();
                match_field("takeover", oldest_cmd.takeover, takeover);
                match_field("left_target", oldest_cmd.left_w, left_target);
                match_field("right_target", oldest_cmd.right_w, right_target);
                match_field("turn_kind", oldest_cmd.kind, turn_kind);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("turn_maneuver_sequencer test failed");
            $finish;
        end
    end

    initial begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!pressure_done && sent_count >= HOLD_AFTER) begin
                pressure_on = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                pressure_on = 1'b0;
                pressure_done = 1'b1;
            end
            else begin
                int stall_len;
                if ($urandom_range(0, 149) == 0)
                    rx_calm = !rx_calm;
                stall_len = pick_gap(rx_calm);
                out_stall <= (stall_len != 0);
                if (stall_len > 1)
                    repeat (stall_len - 1) @(negedge clk);
            end
        end
    end

    initial begin
        int phase_start;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sensor_bits = '0;
        now_ms = '0;
        restart = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < ROUTE_ROWS; i++)
            send_request(ROUTE[i].sensor, ROUTE[i].stamp, ROUTE[i].clear_req,
                         ROUTE[i].typed, ROUTE[i].want);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: program_limits(10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: program_limits(10'd0, 10'd0, 16'd0, 16'd0, 16'd0);
                2: program_limits(SPEED_W'($urandom), SPEED_W'($urandom),
                                  DUR_W'($urandom_range(0, 600)), 16'd400, 16'd150);
                default: program_limits(SPEED_W'($urandom), SPEED_W'($urandom),
                                        DUR_W'($urandom_range(0, 1000)),
                                        DUR_W'($urandom_range(0, 1000)),
                                        DUR_W'($urandom_range(0, 1000)));
            endcase
            if (ph == 4)
                write_reg(REG_TURN_END + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 8)
                    send_request(SENSOR_W'($urandom), TIME_W'($urandom),
                                 $urandom_range(0, 19) == 0, 1'b0, '0);
                else
                    drive_episode();
            end
            wait_idle();
        end

        if (errors == 0)
            $display("turn_maneuver_sequencer test passed");
        else
            $display("turn_maneuver_sequencer test failed");
        $finish;
    end
endmodule
